>>> hw/rtl/rtp_sequence_loss_tracker_unit_assert.svh
// Assertion macros for the RTP sequence loss tracker.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef RTP_SEQUENCE_LOSS_TRACKER_UNIT_ASSERT_SVH
`define RTP_SEQUENCE_LOSS_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define RSLT_ASSERT_SAME(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define RSLT_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RSLT_ASSERT_SAME(label, ante, cons, msg)
`define RSLT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hw/rtl/rslt_pkg.sv
// Shared types and constants of the RTP sequence loss tracker.
// Used by rtp_sequence_loss_tracker_unit; depends on nothing.
package rslt_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_DROPOUT    = 2'd0;
	localparam logic [1:0] REG_MAX_MISORDER   = 2'd1;
	localparam logic [1:0] REG_MIN_SEQUENTIAL = 2'd2;

	// Register reset values.
	localparam logic [15:0] MAX_DROPOUT_RST    = 16'd3000;
	localparam logic [15:0] MAX_MISORDER_RST   = 16'd100;
	localparam logic [7:0]  MIN_SEQUENTIAL_RST = 8'd2;

	// Sequence number space and related constants.
	localparam logic [16:0] SEQ_MOD      = 17'h10000;
	localparam logic [15:0] SEQ_LAST     = 16'hFFFF;
	localparam logic [7:0]  FRACTION_MAX = 8'hFF;

	// Operation codes carried in the input tuser.
	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PKT,
		ST_WRAP,
		ST_RCV,
		ST_R_EXP1,
		ST_R_EXP2,
		ST_R_EXP3,
		ST_R_LOST,
		ST_R_EI,
		ST_R_RI,
		ST_R_LI,
		ST_R_CMP,
		ST_R_DIV,
		ST_OUT
	} state_t;

endpackage

>>> hw/rtl/rtp_sequence_loss_tracker_unit.sv
// RTP sequence loss tracker: sequence validation and loss statistics.
// Depends on rslt_pkg and rtp_sequence_loss_tracker_unit_assert.svh.
//   The slave stream carries one item per transaction: s_tuser is the
//   operation (0 packet arrival, 1 loss report), s_tdata the 16-bit
//   sequence number. Each item yields exactly one transaction on the
//   master stream: m_tuser is the accepted flag, m_tdata packs the total
//   lost count, the 8-bit loss fraction and the extended highest number.
//   The statistics arithmetic runs through one 33-bit add/subtract unit under a small
//   sequencer, so the block takes one item at a time.
//   A packet passes through the decision, an optional wrap count, an optional
//   received count and the output load before m_tvalid rises.
//   A report runs seven add/subtract steps, one compare, an 8-step
//   restoring division and the output load; the division is skipped when the
//   fraction is zero or saturated, and a report before any nonzero highest
//   number goes straight to the output load. s_tready rises in the cycle
//   after the result is loaded.
//   While the receiver stalls, one result waits in the output register and
//   the next item is taken and held at the output step.
//   Configuration writes on the cfg channel are always taken (cfg_ready
//   high) and must only happen while the block is idle.
//   Reset clears all statistics and loads the register defaults.
`include "rtp_sequence_loss_tracker_unit_assert.svh"

module rtp_sequence_loss_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] seq
	input  logic        s_tuser,    // [0] op
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,    // [31:0] lost count, [39:32] loss fraction,
	                                // [71:40] extended highest number
	output logic        m_tuser,    // [0] accepted
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	rslt_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [15:0] max_dropout_q;
	logic [15:0] max_misorder_q;
	logic [7:0]  min_sequential_q;

	// Tracking state.
	logic [15:0] highest_seq_q;
	logic [31:0] wrap_count_q;
	logic [15:0] first_seq_q;
	logic [15:0] expected_bad_q;
	logic [7:0]  probation_left_q;
	logic [31:0] received_count_q;
	logic [31:0] expected_at_report_q;
	logic [31:0] received_at_report_q;
	logic [31:0] lost_total_q;
	logic [7:0]  lost_fraction_q;

	// Working registers of the sequencer.
	logic [15:0] seq_q;
	logic        accepted_q;
	logic [31:0] work_q;
	logic [31:0] exp_int_q;
	logic [31:0] rem_q;
	logic [2:0]  div_cnt_q;
	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;
	logic        m_tuser_q;

	// Shared add/subtract unit.
	logic [32:0] alu_a;
	logic [32:0] alu_b;
	logic        alu_sub;
	logic [33:0] alu_y;
	logic        alu_borrow;

	// Packet decision signals.
	logic [15:0] udelta;
	logic        in_order;
	logic        in_window;
	logic        is_successor;
	logic        pkt_resync;
	logic        pkt_accept;
	logic [7:0]  probation_reload;

	// Report decision signals.
	logic        frac_zero;
	logic        out_load;

	assign s_tready  = (state_q == rslt_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	// The arithmetic unit: a 33-bit adder or subtractor with borrow out.
	assign alu_y      = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                            : ({1'b0, alu_a} + {1'b0, alu_b});
	assign alu_borrow = alu_y[33];

	// Packet classification, valid in ST_PKT where the unit forms seq - highest.
	assign udelta           = alu_y[15:0];
	assign in_order         = (udelta < max_dropout_q);
	assign in_window        = (({1'b0, udelta} + {1'b0, max_misorder_q}) <= rslt_pkg::SEQ_MOD);
	assign is_successor     = (udelta == 16'd1);
	assign probation_reload = (min_sequential_q == 8'd0) ? 8'd0 : (min_sequential_q - 8'd1);

	// Resync and acceptance outcome of a packet.
	always_comb begin
		pkt_resync = 1'b0;
		pkt_accept = 1'b0;
		if (probation_left_q != 8'd0) begin
			if (is_successor && (probation_left_q == 8'd1)) begin
				pkt_resync = 1'b1;
				pkt_accept = 1'b1;
			end
		end else if (in_order) begin
			pkt_accept = 1'b1;
		end else if (in_window) begin
			if (seq_q == expected_bad_q) begin
				pkt_resync = 1'b1;
				pkt_accept = 1'b1;
			end
		end else begin
			pkt_accept = 1'b1;
		end
	end

	// Fraction is zero when nothing was expected or the interval loss is not positive.
	assign frac_zero = (exp_int_q == 32'd0) || (work_q == 32'd0) || work_q[31];
	assign out_load  = !m_tvalid_q || m_tready;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rslt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and operand selection of the shared unit.
	always_comb begin
		state_d = state_q;
		alu_a   = 33'd0;
		alu_b   = 33'd0;
		alu_sub = 1'b0;
		case (state_q)
			rslt_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == rslt_pkg::OP_PACKET) begin
						state_d = rslt_pkg::ST_PKT;
					end else if (highest_seq_q == 16'd0) begin
						state_d = rslt_pkg::ST_OUT;
					end else begin
						state_d = rslt_pkg::ST_R_EXP1;
					end
				end
			end
			rslt_pkg::ST_PKT: begin
				alu_a   = {17'd0, seq_q};
				alu_b   = {17'd0, highest_seq_q};
				alu_sub = 1'b1;
				if (probation_left_q != 8'd0) begin
					state_d = pkt_resync ? rslt_pkg::ST_RCV : rslt_pkg::ST_OUT;
				end else if (in_order) begin
					state_d = alu_borrow ? rslt_pkg::ST_WRAP : rslt_pkg::ST_RCV;
				end else if (in_window) begin
					state_d = pkt_resync ? rslt_pkg::ST_RCV : rslt_pkg::ST_OUT;
				end else begin
					state_d = rslt_pkg::ST_OUT;
				end
			end
			rslt_pkg::ST_WRAP: begin
				alu_a   = {1'b0, wrap_count_q};
				alu_b   = {16'd0, rslt_pkg::SEQ_MOD};
				state_d = rslt_pkg::ST_RCV;
			end
			rslt_pkg::ST_RCV: begin
				alu_a   = {1'b0, received_count_q};
				alu_b   = 33'd1;
				state_d = rslt_pkg::ST_OUT;
			end
			rslt_pkg::ST_R_EXP1: begin
				alu_a   = {1'b0, wrap_count_q};
				alu_b   = {17'd0, highest_seq_q};
				state_d = rslt_pkg::ST_R_EXP2;
			end
			rslt_pkg::ST_R_EXP2: begin
				alu_a   = {1'b0, work_q};
				alu_b   = {17'd0, first_seq_q};
				alu_sub = 1'b1;
				state_d = rslt_pkg::ST_R_EXP3;
			end
			rslt_pkg::ST_R_EXP3: begin
				alu_a   = {1'b0, work_q};
				alu_b   = 33'd1;
				state_d = rslt_pkg::ST_R_LOST;
			end
			rslt_pkg::ST_R_LOST: begin
				alu_a   = {1'b0, work_q};
				alu_b   = {1'b0, received_count_q};
				alu_sub = 1'b1;
				state_d = rslt_pkg::ST_R_EI;
			end
			rslt_pkg::ST_R_EI: begin
				alu_a   = {1'b0, work_q};
				alu_b   = {1'b0, expected_at_report_q};
				alu_sub = 1'b1;
				state_d = rslt_pkg::ST_R_RI;
			end
			rslt_pkg::ST_R_RI: begin
				alu_a   = {1'b0, received_count_q};
				alu_b   = {1'b0, received_at_report_q};
				alu_sub = 1'b1;
				state_d = rslt_pkg::ST_R_LI;
			end
			rslt_pkg::ST_R_LI: begin
				alu_a   = {1'b0, exp_int_q};
				alu_b   = {1'b0, work_q};
				alu_sub = 1'b1;
				state_d = rslt_pkg::ST_R_CMP;
			end
			rslt_pkg::ST_R_CMP: begin
				// Loss not below the expected count saturates the fraction.
				alu_a   = {1'b0, work_q};
				alu_b   = {1'b0, exp_int_q};
				alu_sub = 1'b1;
				if (frac_zero || !alu_borrow) begin
					state_d = rslt_pkg::ST_OUT;
				end else begin
					state_d = rslt_pkg::ST_R_DIV;
				end
			end
			rslt_pkg::ST_R_DIV: begin
				alu_a   = {rem_q, 1'b0};
				alu_b   = {1'b0, exp_int_q};
				alu_sub = 1'b1;
				if (div_cnt_q == 3'd7) begin
					state_d = rslt_pkg::ST_OUT;
				end
			end
			rslt_pkg::ST_OUT: begin
				alu_a = {1'b0, wrap_count_q};
				alu_b = {17'd0, highest_seq_q};
				if (out_load) begin
					state_d = rslt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rslt_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dropout_q    <= rslt_pkg::MAX_DROPOUT_RST;
			max_misorder_q   <= rslt_pkg::MAX_MISORDER_RST;
			min_sequential_q <= rslt_pkg::MIN_SEQUENTIAL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				rslt_pkg::REG_MAX_DROPOUT:    max_dropout_q    <= cfg_data;
				rslt_pkg::REG_MAX_MISORDER:   max_misorder_q   <= cfg_data;
				rslt_pkg::REG_MIN_SEQUENTIAL: min_sequential_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Tracking state and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_seq_q        <= '0;
			wrap_count_q         <= '0;
			first_seq_q          <= '0;
			expected_bad_q       <= '0;
			probation_left_q     <= '0;
			received_count_q     <= '0;
			expected_at_report_q <= '0;
			received_at_report_q <= '0;
			lost_total_q         <= '0;
			lost_fraction_q      <= '0;
			accepted_q           <= 1'b0;
			div_cnt_q            <= '0;
		end else begin
			case (state_q)
				rslt_pkg::ST_IDLE: begin
					accepted_q <= 1'b0;
				end
				rslt_pkg::ST_PKT: begin
					accepted_q <= pkt_accept;
					if (probation_left_q != 8'd0) begin
						highest_seq_q <= seq_q;
						if (is_successor) begin
							probation_left_q <= probation_left_q - 8'd1;
						end else begin
							probation_left_q <= probation_reload;
						end
					end else if (in_order) begin
						highest_seq_q <= seq_q;
					end else if (in_window && !pkt_resync) begin
						expected_bad_q <= seq_q + 16'd1;
					end else if (pkt_resync) begin
						highest_seq_q <= seq_q;
					end
					if (pkt_resync) begin
						first_seq_q          <= seq_q;
						expected_bad_q       <= rslt_pkg::SEQ_LAST;
						wrap_count_q         <= '0;
						lost_total_q         <= '0;
						lost_fraction_q      <= '0;
						received_count_q     <= '0;
						received_at_report_q <= '0;
						expected_at_report_q <= '0;
					end
				end
				rslt_pkg::ST_WRAP: begin
					wrap_count_q <= alu_y[31:0];
				end
				rslt_pkg::ST_RCV: begin
					received_count_q <= alu_y[31:0];
				end
				rslt_pkg::ST_R_LOST: begin
					lost_total_q <= alu_y[31:0];
				end
				rslt_pkg::ST_R_EI: begin
					expected_at_report_q <= work_q;
				end
				rslt_pkg::ST_R_RI: begin
					received_at_report_q <= received_count_q;
				end
				rslt_pkg::ST_R_CMP: begin
					div_cnt_q <= '0;
					if (frac_zero) begin
						lost_fraction_q <= '0;
					end else if (!alu_borrow) begin
						lost_fraction_q <= rslt_pkg::FRACTION_MAX;
					end else begin
						lost_fraction_q <= '0;
					end
				end
				rslt_pkg::ST_R_DIV: begin
					// One quotient bit per cycle, shifted in from the bottom.
					div_cnt_q       <= div_cnt_q + 3'd1;
					lost_fraction_q <= {lost_fraction_q[6:0], !alu_borrow};
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			rslt_pkg::ST_IDLE: begin
				seq_q <= s_tdata;
			end
			rslt_pkg::ST_R_EXP1, rslt_pkg::ST_R_EXP2, rslt_pkg::ST_R_EXP3,
			rslt_pkg::ST_R_RI, rslt_pkg::ST_R_LI: begin
				work_q <= alu_y[31:0];
			end
			rslt_pkg::ST_R_EI: begin
				exp_int_q <= alu_y[31:0];
			end
			rslt_pkg::ST_R_CMP: begin
				rem_q <= work_q;
			end
			rslt_pkg::ST_R_DIV: begin
				if (!alu_borrow) begin
					rem_q <= alu_y[31:0];
				end else begin
					rem_q <= {rem_q[30:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded from the last step, held while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == rslt_pkg::ST_OUT) && out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == rslt_pkg::ST_OUT) && out_load) begin
			m_tdata_q <= {alu_y[31:0], lost_fraction_q, lost_total_q};
			m_tuser_q <= accepted_q;
		end
	end

	// Assertions.
	`RSLT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, state_q != rslt_pkg::ST_IDLE, "sequencer stayed idle after a transaction")
	`RSLT_ASSERT_NEXT(a_div_ends, (state_q == rslt_pkg::ST_R_DIV) && (div_cnt_q == 3'd7), state_q == rslt_pkg::ST_OUT, "division did not end after eight steps")
	`RSLT_ASSERT_SAME(a_div_rem, state_q == rslt_pkg::ST_R_DIV, rem_q < exp_int_q, "division remainder not below divisor")
	`RSLT_ASSERT_SAME(a_valid_source, $rose(m_tvalid_q), $past(state_q) == rslt_pkg::ST_OUT, "output valid rose outside the output step")

endmodule

>>> sim/rtp_sequence_loss_tracker_unit_tb.sv
// Self-checking testbench for rtp_sequence_loss_tracker_unit: a directed run, then random
// RTP traffic under several limit settings, with every result checked against a tracker model.
// Depends on rslt_pkg and the RTL of rtp_sequence_loss_tracker_unit.
module rtp_sequence_loss_tracker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CLK_PERIOD   = 12;
	localparam int unsigned RESET_CYCLES = 9;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned RUN_LIMIT_NS = 6_000_000;
	localparam int unsigned MAX_SHOWN    = 10;

	// One input item and one result, as the stream buses carry them.
	typedef struct packed {
		logic        op;
		logic [15:0] seq;
	} stream_item_t;

	typedef struct packed {
		logic        accepted;
		logic [31:0] lost_sum;
		logic [7:0]  fraction;
		logic [31:0] ext_max;
	} loss_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic        s_tuser   = rslt_pkg::OP_PACKET;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = rslt_pkg::REG_MAX_DROPOUT;
	logic [15:0] cfg_data  = '0;

	rtp_sequence_loss_tracker_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Tracker limits as last written.
	logic [15:0] dropout_cfg  = rslt_pkg::MAX_DROPOUT_RST;
	logic [15:0] misorder_cfg = rslt_pkg::MAX_MISORDER_RST;
	logic [7:0]  min_seq_cfg  = rslt_pkg::MIN_SEQUENTIAL_RST;

	// Sequence tracking and loss statistics of the stream.
	logic [15:0] hi_seq    = '0;
	logic [15:0] start_seq = '0;
	logic [15:0] bad_seq   = '0;
	logic [7:0]  probation = '0;
	logic [31:0] wraps     = '0;
	logic [31:0] rcv_cnt   = '0;
	logic [31:0] exp_prior = '0;
	logic [31:0] rcv_prior = '0;
	logic [31:0] lost_cum  = '0;
	logic [7:0]  frac      = '0;

	stream_item_t pending[$];
	loss_result_t due_results[$];

	int unsigned n_pkts     = 0;
	int unsigned n_reports  = 0;
	int unsigned n_results  = 0;
	int unsigned n_acc      = 0;
	int unsigned n_mismatch = 0;
	int unsigned n_settings = 1;
	int unsigned gap_left   = 0;
	int unsigned stall_left = 0;
	logic [1:0]  tx_mode    = 2'd0;
	logic [1:0]  rx_mode    = 2'd0;
	logic [15:0] gen_seq    = '0;

	// Start the stream over at sequence number s.
	function automatic void restart_stream(input logic [15:0] s);
		start_seq = s;
		hi_seq    = s;
		bad_seq   = rslt_pkg::SEQ_LAST;
		wraps     = '0;
		lost_cum  = '0;
		frac      = '0;
		rcv_cnt   = '0;
		rcv_prior = '0;
		exp_prior = '0;
	endfunction

	// Sequence check of one packet; returns the accepted flag.
	function automatic logic track_packet(input logic [15:0] s);
		logic [15:0] gap;
		logic [15:0] succ;
		gap  = s - hi_seq;
		succ = hi_seq + 16'd1;
		if (probation != 8'd0) begin
			if (s == succ) begin
				probation = probation - 8'd1;
				hi_seq    = s;
				if (probation == 8'd0) begin
					restart_stream(s);
					rcv_cnt = rcv_cnt + 32'd1;
					return 1'b1;
				end
			end else begin
				probation = (min_seq_cfg == 8'd0) ? 8'd0 : min_seq_cfg - 8'd1;
				hi_seq    = s;
			end
			return 1'b0;
		end
		if (gap < dropout_cfg) begin
			// In order; a smaller number means the 16-bit space wrapped.
			if (s < hi_seq)
				wraps = wraps + {15'd0, rslt_pkg::SEQ_MOD};
			hi_seq = s;
		end else if ({1'b0, gap} <= rslt_pkg::SEQ_MOD - {1'b0, misorder_cfg}) begin
			// Large jump: re-sync only when it follows the previous large jump.
			if (s == bad_seq) begin
				restart_stream(s);
			end else begin
				bad_seq = s + 16'd1;
				return 1'b0;
			end
		end else begin
			// Duplicate or reordered packet, accepted but not counted.
			return 1'b1;
		end
		rcv_cnt = rcv_cnt + 32'd1;
		return 1'b1;
	endfunction

	// Cumulative loss and the loss fraction of the interval since the last report.
	function automatic void take_report();
		logic [31:0] total_exp;
		logic [31:0] exp_int;
		logic [31:0] rcv_int;
		logic [31:0] lost_int;
		logic [39:0] quo;
		if (hi_seq == 16'd0)
			return;
		total_exp = wraps + {16'd0, hi_seq} - {16'd0, start_seq} + 32'd1;
		lost_cum  = total_exp - rcv_cnt;
		exp_int   = total_exp - exp_prior;
		exp_prior = total_exp;
		rcv_int   = rcv_cnt - rcv_prior;
		rcv_prior = rcv_cnt;
		lost_int  = exp_int - rcv_int;
		if (exp_int == 32'd0 || lost_int == 32'd0 || lost_int[31]) begin
			frac = '0;
		end else begin
			quo  = {lost_int, 8'd0} / {8'd0, exp_int};
			frac = (quo > 40'd255) ? rslt_pkg::FRACTION_MAX : quo[7:0];
		end
	endfunction

	function automatic loss_result_t predict_item(input logic op, input logic [15:0] s);
		loss_result_t r;
		r.accepted = 1'b0;
		if (op == rslt_pkg::OP_PACKET)
			r.accepted = track_packet(s);
		else
			take_report();
		r.lost_sum = lost_cum;
		r.fraction = frac;
		r.ext_max  = wraps + {16'd0, hi_seq};
		return r;
	endfunction

	// Wait drawn per transaction: none, occasional or frequent.
	function automatic int unsigned pick_wait(input logic [1:0] mode);
		if (mode == 2'd0)
			return 0;
		if (mode == 2'd1)
			return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic void push_item(input logic op, input logic [15:0] s);
		stream_item_t it;
		it.op  = op;
		it.seq = s;
		pending.push_back(it);
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		n_mismatch++;
		if (n_mismatch <= MAX_SHOWN)
			$display("MISMATCH at %0t on result %0d, %s: expected 0x%0h, got 0x%0h",
				$realtime, n_results, what, want, got);
	endtask

	// Mostly well-formed streams with losses, reorders, re-syncs and wraps, plus noise.
	task automatic queue_traffic(input int unsigned count);
		int unsigned made;
		int unsigned roll;
		logic [15:0] step;
		logic [15:0] jump;
		made = 0;
		while (made < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				step = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(2, 5)) : 16'd1;
				gen_seq = gen_seq + step;
				push_item(rslt_pkg::OP_PACKET, gen_seq);
				made++;
			end else if (roll < 60) begin
				step = 16'($urandom_range(0, 65535));
				push_item(rslt_pkg::OP_REPORT, step);
				made++;
			end else if (roll < 70) begin
				step = 16'($urandom_range(0, 30));
				push_item(rslt_pkg::OP_PACKET, gen_seq - step);
				made++;
			end else if (roll < 82) begin
				// Large jump, usually followed by its successor so the stream re-syncs.
				jump = ($urandom_range(0, 2) == 0)
					? rslt_pkg::SEQ_LAST - 16'($urandom_range(0, 8))
					: 16'($urandom_range(0, 65535));
				push_item(rslt_pkg::OP_PACKET, jump);
				gen_seq = jump;
				made++;
				if ($urandom_range(0, 4) != 0) begin
					gen_seq = jump + 16'd1;
					push_item(rslt_pkg::OP_PACKET, gen_seq);
					made++;
				end
			end else if (roll < 92) begin
				step = 16'($urandom_range(1, 6000));
				gen_seq = gen_seq + step;
				push_item(rslt_pkg::OP_PACKET, gen_seq);
				made++;
			end else begin
				step = 16'($urandom_range(0, 65535));
				push_item(rslt_pkg::OP_PACKET, step);
				made++;
			end
		end
	endtask

	// Blocks until the block has nothing left to do, then lets it settle.
	task automatic wait_idle();
		while (pending.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			rslt_pkg::REG_MAX_DROPOUT:    dropout_cfg  = val;
			rslt_pkg::REG_MAX_MISORDER:   misorder_cfg = val;
			rslt_pkg::REG_MIN_SEQUENTIAL: min_seq_cfg  = val[7:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic program_limits(input logic [15:0] dropout, input logic [15:0] misorder,
			input logic [7:0] min_seq);
		write_reg(rslt_pkg::REG_MAX_DROPOUT, dropout);
		write_reg(rslt_pkg::REG_MAX_MISORDER, misorder);
		write_reg(rslt_pkg::REG_MIN_SEQUENTIAL, {8'd0, min_seq});
		n_settings++;
	endtask

	// Input driver: presents queued items with random gaps between transactions.
	always @(posedge clk) begin
		stream_item_t nxt;
		logic hold;
		if (arst_n) begin
			hold = s_tvalid;
			if (s_tvalid && s_tready) begin
				due_results.push_back(predict_item(s_tuser, s_tdata));
				if (s_tuser == rslt_pkg::OP_PACKET)
					n_pkts++;
				else
					n_reports++;
				hold = 1'b0;
				gap_left = pick_wait(tx_mode);
				if ((n_pkts + n_reports) % 64 == 0)
					tx_mode = 2'($urandom_range(0, 2));
			end
			if (!hold) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending.size() != 0) begin
					nxt = pending.pop_front();
					s_tuser <= nxt.op;
					s_tdata <= nxt.seq;
					hold = 1'b1;
				end
			end
			s_tvalid <= hold;
		end
	end

	// Output monitor: checks each result transaction and stalls the receiver at random.
	always @(posedge clk) begin
		loss_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (m_tuser)
					n_acc++;
				if (due_results.size() == 0) begin
					note_mismatch("result with nothing pending", 32'd0, m_tdata[31:0]);
				end else begin
					want = due_results.pop_front();
					if (m_tuser !== want.accepted)
						note_mismatch("accepted", {31'd0, want.accepted}, {31'd0, m_tuser});
					if (m_tdata[31:0] !== want.lost_sum)
						note_mismatch("cumulative loss", want.lost_sum, m_tdata[31:0]);
					if (m_tdata[39:32] !== want.fraction)
						note_mismatch("loss fraction", {24'd0, want.fraction},
							{24'd0, m_tdata[39:32]});
					if (m_tdata[71:40] !== want.ext_max)
						note_mismatch("extended highest", want.ext_max, m_tdata[71:40]);
				end
				stall_left = pick_wait(rx_mode);
				if (n_results % 64 == 0)
					rx_mode = 2'($urandom_range(0, 2));
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus sequence: directed items, then random traffic under several limit settings.
	initial begin
		logic [15:0] rnd_dropout;
		logic [15:0] rnd_misorder;
		logic [7:0]  rnd_min_seq;
		tx_mode = 2'($urandom_range(0, 2));
		rx_mode = 2'($urandom_range(0, 2));
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reports before any nonzero highest number change nothing.
		push_item(rslt_pkg::OP_REPORT, 16'h0000);
		push_item(rslt_pkg::OP_PACKET, 16'd0);
		push_item(rslt_pkg::OP_REPORT, 16'hFFFF);
		// In order, one lost, then a duplicate and a reorder.
		push_item(rslt_pkg::OP_PACKET, 16'd1);
		push_item(rslt_pkg::OP_PACKET, 16'd2);
		push_item(rslt_pkg::OP_PACKET, 16'd4);
		push_item(rslt_pkg::OP_REPORT, 16'd0);
		push_item(rslt_pkg::OP_PACKET, 16'd4);
		push_item(rslt_pkg::OP_PACKET, 16'd3);
		push_item(rslt_pkg::OP_REPORT, 16'd0);
		push_item(rslt_pkg::OP_PACKET, 16'hFFFF);
		// Two unrelated large jumps, then the successor of the second re-syncs.
		push_item(rslt_pkg::OP_PACKET, 16'd9000);
		push_item(rslt_pkg::OP_PACKET, 16'd20000);
		push_item(rslt_pkg::OP_PACKET, 16'd20001);
		push_item(rslt_pkg::OP_PACKET, 16'd20002);
		push_item(rslt_pkg::OP_REPORT, 16'd0);
		// Re-sync just under the top, then wrap around zero with a loss.
		push_item(rslt_pkg::OP_PACKET, 16'hFFFE);
		push_item(rslt_pkg::OP_PACKET, 16'hFFFF);
		push_item(rslt_pkg::OP_PACKET, 16'd0);
		push_item(rslt_pkg::OP_PACKET, 16'd3);
		push_item(rslt_pkg::OP_REPORT, 16'd0);
		push_item(rslt_pkg::OP_PACKET, 16'd23);
		push_item(rslt_pkg::OP_REPORT, 16'hFFFF);
		push_item(rslt_pkg::OP_REPORT, 16'h5A5A);
		gen_seq = 16'd23;
		queue_traffic(250);

		for (int p = 0; p < 7; p++) begin
			wait_idle();
			case (p)
				0: program_limits(16'hFFFF, 16'hFFFF, 8'hFF);
				1: program_limits(16'd1, 16'd1, 8'd1);
				2: program_limits(16'd0, 16'd0, 8'd0);
				default: begin
					rnd_dropout  = ($urandom_range(0, 1) != 0)
						? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 4000));
					rnd_misorder = ($urandom_range(0, 1) != 0)
						? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 300));
					rnd_min_seq  = 8'($urandom_range(1, 255));
					program_limits(rnd_dropout, rnd_misorder, rnd_min_seq);
				end
			endcase
			queue_traffic((p < 3) ? 220 : 170);
		end

		wait_idle();
		$display("Run covered %0d packet and %0d report items under %0d limit settings.",
			n_pkts, n_reports, n_settings);
		$display("%0d results checked, %0d flagged accepted, %0d mismatches.",
			n_results, n_acc, n_mismatch);
		if (n_mismatch == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Timed out with %0d results still outstanding.", due_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
